@@ src/mrpt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mrpt_pkg
// Shared types and constants of the 64-bit Miller-Rabin prime tester.
// ----------------------------------------------------------------------------
package mrpt_pkg;

  localparam int unsigned WordW = 64;

  // register indexes of the configuration port
  localparam logic RegTestMode = 1'b0;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIAL,
    ST_TRIAL_W,
    ST_SPLIT,
    ST_BASE,
    ST_BASE_W,
    ST_SQ,
    ST_SQ_W,
    ST_MUL,
    ST_MUL_W,
    ST_CHECK,
    ST_RSQ,
    ST_RSQ_W,
    ST_DONE
  } state_e;

  // request to the serial modular multiplier
  typedef struct packed {
    logic               start;
    logic [WordW-1:0]   mcand;
    logic [WordW-1:0]   mplier;
    logic [WordW-1:0]   modulus;
  } mm_req_t;

  // reply from the serial modular multiplier
  typedef struct packed {
    logic               done;
    logic [WordW-1:0]   result;
  } mm_rsp_t;

  // trial divisors: 3 then the primes 5 to 37
  localparam int unsigned NumTrial = 11;
  function automatic logic [5:0] trial_prime(input logic [3:0] idx);
    logic [5:0] p;
    unique case (idx)
      4'd0:    p = 6'd3;
      4'd1:    p = 6'd5;
      4'd2:    p = 6'd7;
      4'd3:    p = 6'd11;
      4'd4:    p = 6'd13;
      4'd5:    p = 6'd17;
      4'd6:    p = 6'd19;
      4'd7:    p = 6'd23;
      4'd8:    p = 6'd29;
      4'd9:    p = 6'd31;
      default: p = 6'd37;
    endcase
    return p;
  endfunction

  // fixed witness bases of the full test
  localparam int unsigned NumBases = 7;
  function automatic logic [30:0] full_base(input logic [3:0] idx);
    logic [30:0] b;
    unique case (idx)
      4'd0:    b = 31'd2;
      4'd1:    b = 31'd325;
      4'd2:    b = 31'd9375;
      4'd3:    b = 31'd28178;
      4'd4:    b = 31'd450775;
      4'd5:    b = 31'd9780504;
      default: b = 31'd1795265022;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

@@ src/mrpt_modmul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mrpt_modmul
// Bit-serial interleaved modular multiplier: result = mcand * mplier mod m.
// One multiplier bit per cycle, MSB first; needs mcand < m. With mcand = 1 it
// gives the plain remainder mplier mod m.
// ----------------------------------------------------------------------------
module mrpt_modmul (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mrpt_pkg::mm_req_t req_i,
  output mrpt_pkg::mm_rsp_t     rsp_o
);
  import mrpt_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [WordW-1:0] acc_q, acc_d;
  logic [WordW-1:0] b_q, b_d;
  logic [WordW-1:0] a_q, a_d;
  logic [WordW-1:0] m_q, m_d;
  logic [WordW:0]   dbl, dbl_r, add, add_r;

  // one step: acc = 2*acc (+ a) mod m
  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    add   = dbl_r + {1'b0, a_q};
    add_r = (add >= {1'b0, m_q}) ? add - {1'b0, m_q} : add;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    b_d    = b_q;
    a_d    = a_q;
    m_d    = m_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd63;
      acc_d  = '0;
      a_d    = req_i.mcand;
      b_d    = req_i.mplier;
      m_d    = req_i.modulus;
    end else if (busy_q) begin
      acc_d = b_q[WordW-1] ? add_r[WordW-1:0] : dbl_r[WordW-1:0];
      b_d   = {b_q[WordW-2:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    b_q   <= b_d;
    a_q   <= a_d;
    m_q   <= m_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = acc_q;

endmodule
`default_nettype wire

@@ src/miller_rabin_prime_test_u64.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_u64
// 64-bit primality test: small cases, trial division (full mode only), then
// strong probable-prime rounds on a bit-serial modular multiplier; deterministic in full mode.
//
//  channel  | signals                       | direction
//  ---------+-------------------------------+----------
//  input    | in_valid_i, in_stall_o, n_value_i  | in
//  output   | out_valid_o, out_stall_i, is_prime_o | out
//  config   | APB: psel..pready, test_mode at 0   | in/out
//
// Each modular product has an issue step, 64 serial steps and a done step.
// A round is at most 128 products (base reduction, 64 squarings, one multiply
// per set bit of d, s-1 closing squarings).
// One word at a time: in_stall_o is high while a word is in work. A finished
// word waits in the output register; a new word is taken meanwhile.
// Reset clears control state and test_mode.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_u64 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] n_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             is_prime_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mrpt_pkg::*;

  state_e           state_q, state_d;
  logic             mode_q, mode_d;
  logic             test_mode_q;
  logic [WordW-1:0] n_q, n_d, d_q, d_d, a_q, a_d, x_q, x_d;
  logic [6:0]       s_q, s_d, r_q, r_d;
  logic [5:0]       bit_q, bit_d;
  logic [3:0]       idx_q, idx_d;
  logic             res_q, res_d;
  logic             out_valid_q, out_valid_d;
  logic             out_q, out_d;
  logic [WordW-1:0] n_m1;
  logic             last_base;
  mm_req_t          mm_req;
  mm_rsp_t          mm_rsp;

  mrpt_modmul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegTestMode) ? {31'd0, test_mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      test_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegTestMode) begin
      test_mode_q <= pwdata[0];
    end
  end

  assign n_m1      = n_q - 64'd1;
  assign last_base = mode_q ? (idx_q == 4'd1) : (idx_q == 4'(NumBases - 1));

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign is_prime_o  = out_q;

  // controller
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    n_d         = n_q;
    d_d         = d_q;
    a_d         = a_q;
    x_d         = x_q;
    s_d         = s_q;
    r_d         = r_q;
    bit_d       = bit_q;
    idx_d       = idx_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mm_req      = '{start: 1'b0, mcand: x_q, mplier: x_q, modulus: n_q};

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          n_d    = n_value_i;
          mode_d = test_mode_q;
          idx_d  = '0;
          d_d    = n_value_i - 64'd1;
          s_d    = '0;
          state_d = ST_DONE;
          if (n_value_i < 64'd2) begin
            res_d = 1'b0;
          end else if (n_value_i == 64'd2 || n_value_i == 64'd3) begin
            res_d = 1'b1;
          end else if (!n_value_i[0]) begin
            res_d = 1'b0;
          end else if (test_mode_q) begin
            state_d = ST_SPLIT;
          end else begin
            state_d = ST_TRIAL;
          end
        end
      end

      ST_TRIAL: begin
        if (n_q == {58'd0, trial_prime(idx_q)}) begin
          res_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          mm_req  = '{start: 1'b1, mcand: 64'd1, mplier: n_q,
                      modulus: {58'd0, trial_prime(idx_q)}};
          state_d = ST_TRIAL_W;
        end
      end

      ST_TRIAL_W: begin
        if (mm_rsp.done) begin
          if (mm_rsp.result == '0) begin
            res_d   = 1'b0;
            state_d = ST_DONE;
          end else if (idx_q == 4'(NumTrial - 1)) begin
            idx_d   = '0;
            state_d = ST_SPLIT;
          end else begin
            idx_d   = idx_q + 4'd1;
            state_d = ST_TRIAL;
          end
        end
      end

      // n-1 = d * 2^s, one shift a cycle
      ST_SPLIT: begin
        if (!d_q[0]) begin
          d_d = {1'b0, d_q[WordW-1:1]};
          s_d = s_q + 7'd1;
        end else begin
          idx_d   = '0;
          state_d = ST_BASE;
        end
      end

      ST_BASE: begin
        x_d   = 64'd1;
        bit_d = 6'd63;
        if (mode_q) begin
          a_d     = (idx_q == 4'd0) ? 64'd2 : 64'd3;
          state_d = ST_SQ;
        end else begin
          mm_req  = '{start: 1'b1, mcand: 64'd1, mplier: {33'd0, full_base(idx_q)},
                      modulus: n_q};
          state_d = ST_BASE_W;
        end
      end

      ST_BASE_W: begin
        if (mm_rsp.done) begin
          a_d = mm_rsp.result;
          if (mm_rsp.result == '0) begin
            // base is a multiple of n: skip it
            if (last_base) begin
              res_d   = 1'b1;
              state_d = ST_DONE;
            end else begin
              idx_d   = idx_q + 4'd1;
              state_d = ST_BASE;
            end
          end else begin
            state_d = ST_SQ;
          end
        end
      end

      // left-to-right square and multiply over d
      ST_SQ: begin
        mm_req  = '{start: 1'b1, mcand: x_q, mplier: x_q, modulus: n_q};
        state_d = ST_SQ_W;
      end

      ST_SQ_W: begin
        if (mm_rsp.done) begin
          x_d = mm_rsp.result;
          if (d_q[bit_q]) begin
            state_d = ST_MUL;
          end else if (bit_q == 6'd0) begin
            state_d = ST_CHECK;
          end else begin
            bit_d   = bit_q - 6'd1;
            state_d = ST_SQ;
          end
        end
      end

      ST_MUL: begin
        mm_req  = '{start: 1'b1, mcand: a_q, mplier: x_q, modulus: n_q};
        state_d = ST_MUL_W;
      end

      ST_MUL_W: begin
        if (mm_rsp.done) begin
          x_d = mm_rsp.result;
          if (bit_q == 6'd0) begin
            state_d = ST_CHECK;
          end else begin
            bit_d   = bit_q - 6'd1;
            state_d = ST_SQ;
          end
        end
      end

      ST_CHECK: begin
        r_d = 7'd1;
        if (x_q == 64'd1 || x_q == n_m1) begin
          if (last_base) begin
            res_d   = 1'b1;
            state_d = ST_DONE;
          end else begin
            idx_d   = idx_q + 4'd1;
            state_d = ST_BASE;
          end
        end else if (s_q > 7'd1) begin
          state_d = ST_RSQ;
        end else begin
          res_d   = 1'b0;
          state_d = ST_DONE;
        end
      end

      ST_RSQ: begin
        mm_req  = '{start: 1'b1, mcand: x_q, mplier: x_q, modulus: n_q};
        state_d = ST_RSQ_W;
      end

      ST_RSQ_W: begin
        if (mm_rsp.done) begin
          x_d = mm_rsp.result;
          r_d = r_q + 7'd1;
          if (mm_rsp.result == n_m1) begin
            if (last_base) begin
              res_d   = 1'b1;
              state_d = ST_DONE;
            end else begin
              idx_d   = idx_q + 4'd1;
              state_d = ST_BASE;
            end
          end else if (r_q + 7'd1 < s_q) begin
            state_d = ST_RSQ;
          end else begin
            res_d   = 1'b0;
            state_d = ST_DONE;
          end
        end
      end

      // hand the word to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    n_q    <= n_d;
    d_q    <= d_d;
    a_q    <= a_d;
    x_q    <= x_d;
    s_q    <= s_d;
    r_q    <= r_d;
    bit_q  <= bit_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Checks the 64-bit Miller-Rabin prime tester: directed corner values and
// random candidates (mostly odd, many built as products or near 2^64) are
// fed through the word handshake under several idling phases and both test
// modes; every result is compared against an in-bench primality predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import mrpt_pkg::*;

  localparam int unsigned MaxCycles = 40_000_000;
  localparam int unsigned DrainCycles = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] n_value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        is_prime_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  miller_rabin_prime_test_u64 DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .n_value_i(n_value_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .is_prime_o(is_prime_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [63:0] cand_q[$];
  logic        verdict_q[$];
  logic        mode_r;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;
  int unsigned cycles;

  // ---------------------------------------------------------------- predictor
  function automatic logic [63:0] redc_mul(logic [63:0] a, logic [63:0] b,
                                           logic [63:0] n, logic [63:0] ninv);
    logic [127:0] ab;
    logic [127:0] mn;
    logic [63:0]  m;
    logic [128:0] sum;
    logic [64:0]  hi;
    ab = a * b;
    m = ab[63:0] * ninv;
    mn = m * n;
    sum = {1'b0, ab} + {1'b0, mn};
    hi = sum[128:64];
    if (hi >= {1'b0, n}) hi = hi - {1'b0, n};
    return hi[63:0];
  endfunction

  function automatic bit strong_pass(logic [63:0] n, logic [63:0] a, logic [63:0] ninv,
                                     logic [63:0] r2, logic [63:0] d, int s);
    logic [63:0] one_m;
    logic [63:0] neg_m;
    logic [63:0] b;
    logic [63:0] x;
    logic [63:0] e;
    one_m = redc_mul(64'd1, r2, n, ninv);
    neg_m = redc_mul(n - 64'd1, r2, n, ninv);
    b = redc_mul(a, r2, n, ninv);
    x = one_m;
    e = d;
    while (e != 0) begin
      if (e[0]) x = redc_mul(x, b, n, ninv);
      b = redc_mul(b, b, n, ninv);
      e = e >> 1;
    end
    if (x == one_m || x == neg_m) return 1'b1;
    for (int r = 1; r < s; r++) begin
      x = redc_mul(x, x, n, ninv);
      if (x == neg_m) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic predict_prime(logic [63:0] n, logic fast);
    logic [63:0] divisors[10];
    logic [63:0] witnesses[7];
    logic [63:0] d;
    logic [63:0] ninv;
    logic [63:0] r2;
    logic [64:0] t;
    logic [63:0] a;
    int s;
    divisors = '{64'd5, 64'd7, 64'd11, 64'd13, 64'd17, 64'd19, 64'd23, 64'd29,
                 64'd31, 64'd37};
    witnesses = '{64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504,
                  64'd1795265022};
    s = 0;
    if (n < 2) return 1'b0;
    if (n == 2 || n == 3) return 1'b1;
    if (!n[0]) return 1'b0;
    if (!fast) begin
      if (n % 3 == 0) return 1'b0;
      for (int i = 0; i < 10; i++) begin
        if (n == divisors[i]) return 1'b1;
        if (n % divisors[i] == 0) return 1'b0;
      end
    end
    d = n - 1;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    ninv = 64'd1;
    for (int i = 0; i < 6; i++) ninv = ninv * (64'd2 - n * ninv);
    ninv = 64'd0 - ninv;
    // 2^128 mod n by doubling 2^64 mod n
    r2 = (64'd0 - n) % n;
    for (int i = 0; i < 64; i++) begin
      t = {r2, 1'b0};
      if (t >= {1'b0, n}) t = t - {1'b0, n};
      r2 = t[63:0];
    end
    if (fast)
      return strong_pass(n, 64'd2, ninv, r2, d, s) && strong_pass(n, 64'd3, ninv, r2, d, s);
    for (int i = 0; i < 7; i++) begin
      a = witnesses[i] % n;
      if (a != 0 && !strong_pass(n, a, ninv, r2, d, s)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------- clock/reset
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------- driver
  // the queue head is the word on the bus until it is accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      n_value_i  <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) void'(cand_q.pop_front());
      if (cand_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        n_value_i  <= cand_q[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // expectation is formed on acceptance, with the mode in force
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      verdict_q.push_back(predict_prime(n_value_i, mode_r));
  end

  // ------------------------------------------------------------------ monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: is_prime=%0b", is_prime_o);
        end else begin
          if (is_prime_o !== verdict_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("is_prime mismatch: expected %0b actual %0b",
                       verdict_q[0], is_prime_o);
          end
          void'(verdict_q.pop_front());
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ----------------------------------------------------------- cycle watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------ config writes
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr[2] == RegTestMode) mode_r = data[0];
  endtask

  task automatic wait_idle();
    while (cand_q.size() != 0 || in_valid_i || verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // random candidate: mostly odd, shaped to hit primes and hard composites
  function automatic logic [63:0] random_candidate();
    logic [63:0] v;
    logic [31:0] p;
    logic [31:0] q;
    case ($urandom_range(5))
      0: v = {$urandom, $urandom};
      1: v = {$urandom, $urandom} | 64'd1;
      2: v = {$urandom_range(3), $urandom} | 64'd1;
      3: begin
        p = $urandom | 32'h8000_0001;
        q = $urandom | 32'h8000_0001;
        v = p * q;
      end
      4: begin
        v = 64'hFFFF_FFFF_FFFF_FFFF - 2 * $urandom_range(40);
      end
      default: v = $urandom_range(2000);
    endcase
    return v;
  endfunction

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned count);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) cand_q.push_back(random_candidate());
    wait_idle();
  endtask

  // ---------------------------------------------------------------- stimulus
  initial begin
    logic [63:0] corner[$];
    mismatches = 0; cycles = 0; mode_r = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; n_value_i = '0; out_stall_i = 1'b0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners: small values, trial primes, squares of them, base multiples,
    // strong pseudoprimes to 2 and 3, largest prime and all-ones
    corner = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd9, 64'd5, 64'd37, 64'd41,
               64'd1369, 64'd1373653, 64'd25326001, 64'd3215031751,
               64'd2047, 64'd13, 64'd1795265023,
               64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFF,
               64'h8000_0000_0000_0000, 64'h8000_0000_0000_001D};
    foreach (corner[i]) cand_q.push_back(corner[i]);
    wait_idle();
    reg_write({RegTestMode, 2'b00}, 32'd1);
    foreach (corner[i]) cand_q.push_back(corner[i]);
    wait_idle();
    // only the low bit of the register counts; upper bits set to 1 here
    reg_write({RegTestMode, 2'b00}, 32'hFFFF_FFFE);

    run_phase(0, 0, 25);
    run_phase(78, 0, 20);
    reg_write({RegTestMode, 2'b00}, 32'hFFFF_FFFF);
    run_phase(0, 78, 20);
    run_phase(7, 7, 20);
    reg_write({RegTestMode, 2'b00}, 32'd0);
    run_phase(78, 78, 15);
    run_phase(0, 0, 10);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
